// File: hdl/ifse_pkg.sv
// shared types, byte codes and stuffing helpers for the info frame encoder
package ifse_pkg;

	localparam logic [7:0] FLAG_BYTE  = 8'h7e;
	localparam logic [7:0] ESC_BYTE   = 8'h7d;
	localparam logic [7:0] ESC_FLAG   = 8'h5e;
	localparam logic [7:0] ESC_ESC    = 8'h5d;
	localparam logic [7:0] CTRL_SEQ1  = 8'h40;
	localparam logic [7:0] CTRL_SEQ0  = 8'h00;
	localparam logic [7:0] ADDR_RESET = 8'h03;

	// register byte addresses
	localparam logic [1:0] REG_ADDRESS = 2'd0;

	localparam int unsigned RUN_MAX = 9;

	// one run of output bytes caused by a single input item
	typedef struct packed {
		logic [RUN_MAX-1:0][7:0] bytes;
		logic [3:0]              cnt;
		logic                    closes;
	} run_t;

	// byte that must be escaped on the line
	function automatic logic needs_esc(input logic [7:0] b);
		needs_esc = (b == FLAG_BYTE) || (b == ESC_BYTE);
	endfunction

	// second byte of an escape pair
	function automatic logic [7:0] esc_code(input logic [7:0] b);
		esc_code = (b == FLAG_BYTE) ? ESC_FLAG : ESC_ESC;
	endfunction

endpackage

// File: hdl/ifse_build.sv
// builds the list of framed, stuffed bytes for one payload byte
module ifse_build
	import ifse_pkg::*;
(
	input  logic [7:0] data_byte,
	input  logic       frame_end,
	input  logic       seq_bit,
	input  logic [7:0] address,
	input  logic       in_frame,
	input  logic [7:0] check,
	output run_t       run,
	output logic [7:0] check_next
);

	logic [7:0] ctrl;
	logic [7:0] chk;
	logic [3:0] p;

	// header (frame start), stuffed data, stuffed check and closing flag (frame end) placed in order
	always_comb begin
		run  = '0;
		p    = 4'd0;
		ctrl = seq_bit ? CTRL_SEQ1 : CTRL_SEQ0;
		chk  = (in_frame ? check : 8'h00) ^ data_byte;
		if (!in_frame) begin
			run.bytes[0] = FLAG_BYTE;
			run.bytes[1] = address;
			run.bytes[2] = ctrl;
			run.bytes[3] = address ^ ctrl;
			p = 4'd4;
		end
		if (needs_esc(data_byte)) begin
			run.bytes[p]        = ESC_BYTE;
			run.bytes[p + 4'd1] = esc_code(data_byte);
			p = p + 4'd2;
		end else begin
			run.bytes[p] = data_byte;
			p = p + 4'd1;
		end
		if (frame_end) begin
			if (needs_esc(chk)) begin
				run.bytes[p]        = ESC_BYTE;
				run.bytes[p + 4'd1] = esc_code(chk);
				p = p + 4'd2;
			end else begin
				run.bytes[p] = chk;
				p = p + 4'd1;
			end
			run.bytes[p] = FLAG_BYTE;
			p = p + 4'd1;
		end
		run.cnt    = p;
		run.closes = frame_end;
	end

	assign check_next = frame_end ? 8'h00 : chk;

endmodule

// File: hdl/ifse_serial.sv
// output buffer that hands out one run a byte at a time
module ifse_serial
	import ifse_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       run_valid,
	output logic       run_ready,
	input  run_t       run,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,  // out_byte
	output logic       m_tlast,  // run_last
	output logic       m_tuser   // frame_done
);

	logic [RUN_MAX-1:0][7:0] bytes_s2;
	logic [3:0]              cnt_q;
	logic                    closes_q;
	logic                    take;
	logic                    load;

	assign take      = m_tvalid && m_tready;
	assign run_ready = (cnt_q == 4'd0) || (cnt_q == 4'd1 && m_tready);
	assign load      = run_valid && run_ready;

	// remaining count and run flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= 4'd0;
			closes_q <= 1'b0;
		end else if (load) begin
			cnt_q    <= run.cnt;
			closes_q <= run.closes;
		end else if (take) begin
			cnt_q <= cnt_q - 4'd1;
		end
	end

	// byte list, shifted down as each byte leaves
	always_ff @(posedge clk) begin
		if (load) begin
			bytes_s2 <= run.bytes;
		end else if (take) begin
			bytes_s2 <= {8'h00, bytes_s2[RUN_MAX-1:1]};
		end
	end

	assign m_tvalid = (cnt_q != 4'd0);
	assign m_tdata  = bytes_s2[0];
	assign m_tlast  = (cnt_q == 4'd1);
	assign m_tuser  = closes_q && (cnt_q == 4'd1);

endmodule

// File: hdl/info_frame_stuffing_encoder_unit.sv
// top level of the info frame encoder: config register, frame state, run slot
// Each accepted payload byte turns into a run of 1 to 9 output bytes (frame header
// on the first byte of a frame, the byte itself escaped if it is 0x7e or 0x7d, and on
// the last byte the escaped XOR check and a closing flag). The output side moves one
// byte per cycle while m_tready is high; a run has 1 or 2 bytes inside a frame, up to 5
// on the last byte of a longer frame and up to 9 on a one-byte frame. The run is built
// in the cycle the item is accepted and waits in a one-run slot; when the output is idle
// it moves from the slot into the output buffer, which offers its first byte. A new
// item is taken every cycle the slot is free or about to move into the output buffer.
// The address register is read when the first byte of a frame is accepted; write it
// only while the block is idle.
module info_frame_stuffing_encoder_unit
	import ifse_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // data_byte
	input  logic        s_tlast,   // frame_end
	input  logic        s_tuser,   // seq_bit
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // out_byte
	output logic        m_tlast,   // run_last
	output logic        m_tuser    // frame_done
);

	logic [7:0] address_q;
	logic       in_frame_q;
	logic [7:0] check_q;
	logic [7:0] check_next;
	run_t       run;
	run_t       pend_s1;
	logic       pend_valid_q;
	logic       pend_ready;
	logic       s_take;

	// configuration port
	assign pready = 1'b1;
	assign prdata = (paddr == REG_ADDRESS) ? {24'h000000, address_q} : 32'h00000000;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			address_q <= ADDR_RESET;
		end else if (psel && penable && pwrite && pready && paddr == REG_ADDRESS) begin
			address_q <= pwdata[7:0];
		end
	end

	// run builder
	ifse_build u_build (
		.data_byte (s_tdata),
		.frame_end (s_tlast),
		.seq_bit   (s_tuser),
		.address   (address_q),
		.in_frame  (in_frame_q),
		.check     (check_q),
		.run       (run),
		.check_next(check_next)
	);

	assign s_tready = !pend_valid_q || pend_ready;
	assign s_take   = s_tvalid && s_tready;

	// frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			check_q    <= 8'h00;
		end else if (s_take) begin
			in_frame_q <= !s_tlast;
			check_q    <= check_next;
		end
	end

	// one-run slot between builder and output buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
		end else if (s_take) begin
			pend_valid_q <= 1'b1;
		end else if (pend_ready) begin
			pend_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_take) begin
			pend_s1 <= run;
		end
	end

	ifse_serial u_serial (
		.clk      (clk),
		.arst_n   (arst_n),
		.run_valid(pend_valid_q),
		.run_ready(pend_ready),
		.run      (pend_s1),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	// closing flag always ends its run
	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast && m_tdata == FLAG_BYTE)
		else $error("frame_done not on a closing flag at end of run");

	// last byte of a frame closes the frame and clears the check
	a_frame_closed: assert property (@(posedge clk) disable iff (!arst_n)
		s_take && s_tlast |=> !in_frame_q && check_q == 8'h00)
		else $error("frame state not cleared after last byte");

	// a built run never exceeds nine bytes and is never empty
	a_run_len: assert property (@(posedge clk) disable iff (!arst_n)
		pend_valid_q |-> pend_s1.cnt != 4'd0 && pend_s1.cnt <= 4'd9)
		else $error("run length out of range");

	// first byte of a frame opens with a flag
	a_open_flag: assert property (@(posedge clk) disable iff (!arst_n)
		s_take && !in_frame_q |=> pend_valid_q && pend_s1.bytes[0] == FLAG_BYTE)
		else $error("frame does not open with a flag");

endmodule
